// File: rtl/core/lru_pkg.sv
// Package for the LRU order tracker: field widths, command codes and the
// request/response types of the link store. No dependencies.

package lru_pkg;

  localparam int ENTRY_W = 7;
  localparam int COUNT_W = 8;
  localparam int CMD_W   = 2;
  localparam int LIMIT_W = 7;

  // Entries reachable through the 7-bit entry field
  localparam int ENTRY_SPAN = 1 << ENTRY_W;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd100;

  localparam logic [CMD_W-1:0] CMD_TOUCH     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MAKE_ROOM = 2'd2;

  // One read and one write port on each of the next and prev link memories
  typedef struct packed {
    logic               n_re;
    logic [ENTRY_W-1:0] n_raddr;
    logic               n_we;
    logic [ENTRY_W-1:0] n_waddr;
    logic [ENTRY_W-1:0] n_wdata;
    logic               p_re;
    logic [ENTRY_W-1:0] p_raddr;
    logic               p_we;
    logic [ENTRY_W-1:0] p_waddr;
    logic [ENTRY_W-1:0] p_wdata;
  } link_req_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] n_rdata;
    logic [ENTRY_W-1:0] p_rdata;
  } link_rsp_t;

endpackage

// File: rtl/core/lru_link_store.sv
// Next and prev link memories of the LRU list, registered read data.
// Depends on lru_pkg for the request and response types.

module lru_link_store
  import lru_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  logic      clk,
  input  link_req_t req,
  output link_rsp_t rsp
);

  localparam int AW = $clog2(DEPTH);

  logic [ENTRY_W-1:0] next_mem [DEPTH];
  logic [ENTRY_W-1:0] prev_mem [DEPTH];

  // Write, then read into the registered read data; a read returns the old data
  always_ff @(posedge clk) begin
    if (req.n_we) begin
      next_mem[req.n_waddr[AW-1:0]] <= req.n_wdata;
    end
    if (req.p_we) begin
      prev_mem[req.p_waddr[AW-1:0]] <= req.p_wdata;
    end
    if (req.n_re) begin
      rsp.n_rdata <= next_mem[req.n_raddr[AW-1:0]];
    end
    if (req.p_re) begin
      rsp.p_rdata <= prev_mem[req.p_raddr[AW-1:0]];
    end
  end

endmodule

// File: rtl/core/lru_order_tracker_top.sv
// LRU order tracker: a sequencer that keeps a circular doubly linked list in
// two link memories. Each transaction takes one command and gives one result.
// Steps after an accepted command: one that changes nothing (touch of the
// head, remove of a non-member, make-room without eviction, out-of-range
// entry, unused code) goes straight to S_DONE; a remove passes S_REMOVE,
// the first insert into an empty list S_SELF, a make-room that evicts
// S_EVICT_A and, unless one entry was left, S_EVICT_B, a touch that inserts
// S_LINK_A and S_LINK_B, and a touch that moves a member to the front
// S_UNLINK, S_LINK_A and S_LINK_B. The steps follow the dependent pointer
// reads and writes; each link memory has one registered read port and one
// write port. A result held back by out_stall holds the next command in its
// last step. Membership bits clear at reset; link memories need no clearing.

module lru_order_tracker_top
  import lru_pkg::*;
#(
  parameter int NUM_ENTRIES = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CMD_W-1:0]   cmd,
  input  logic [ENTRY_W-1:0] entry,
  input  logic               eviction_limit_we,
  input  logic [LIMIT_W-1:0] eviction_limit_wdata,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               evicted_valid,
  output logic [ENTRY_W-1:0] evicted_entry,
  output logic [COUNT_W-1:0] entry_count
);

  localparam int DEPTH = (NUM_ENTRIES < ENTRY_SPAN) ? NUM_ENTRIES : ENTRY_SPAN;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_UNLINK  = 4'd1;
  localparam logic [3:0] S_LINK_A  = 4'd2;
  localparam logic [3:0] S_LINK_B  = 4'd3;
  localparam logic [3:0] S_SELF    = 4'd4;
  localparam logic [3:0] S_REMOVE  = 4'd5;
  localparam logic [3:0] S_EVICT_A = 4'd6;
  localparam logic [3:0] S_EVICT_B = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  logic [3:0]         state;
  logic [ENTRY_W-1:0] ent_q;
  logic [ENTRY_W-1:0] head;
  logic [COUNT_W-1:0] count;
  logic [LIMIT_W-1:0] limit;
  logic [ENTRY_W-1:0] nl_q;
  logic [ENTRY_W-1:0] pl_q;
  logic [ENTRY_W-1:0] tail_q;
  logic [ENTRY_W-1:0] last_q;
  logic               moved_q;
  logic               ev_q;
  logic [DEPTH-1:0]   member;

  logic               accept;
  logic               in_range;
  logic               is_member;
  logic               is_head;
  logic               evict_go;
  logic [ENTRY_W-1:0] tail;
  link_req_t          req;
  link_rsp_t          rsp;

  lru_link_store #(
    .DEPTH (DEPTH)
  ) u_link_store (
    .clk (clk),
    .req (req),
    .rsp (rsp)
  );

  // Decode the incoming command against the list state
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign in_range  = ({1'b0, entry} < COUNT_W'(DEPTH));
  assign is_member = in_range && member[entry[AW-1:0]];
  assign is_head   = (entry == head);
  assign evict_go  = (count > {1'b0, limit});

  // Tail for the link-in; forward the unlink write when the head was rewritten
  assign tail = (moved_q && nl_q == head) ? pl_q : rsp.p_rdata;

  // Drive the link memory ports for the current step
  always_comb begin
    req = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_TOUCH: begin
              if (is_member && !is_head) begin
                req.n_re    = 1'b1;
                req.n_raddr = entry;
                req.p_re    = 1'b1;
                req.p_raddr = entry;
              end else if (in_range && !is_member && count != '0) begin
                req.p_re    = 1'b1;
                req.p_raddr = head;
              end
            end
            CMD_REMOVE: begin
              if (is_member) begin
                req.n_re    = 1'b1;
                req.n_raddr = entry;
                req.p_re    = 1'b1;
                req.p_raddr = entry;
              end
            end
            CMD_MAKE_ROOM: begin
              if (evict_go) begin
                req.p_re    = 1'b1;
                req.p_raddr = head;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_UNLINK: begin
        req.p_we    = 1'b1;
        req.p_waddr = rsp.n_rdata;
        req.p_wdata = rsp.p_rdata;
        req.n_we    = 1'b1;
        req.n_waddr = rsp.p_rdata;
        req.n_wdata = rsp.n_rdata;
        req.p_re    = 1'b1;
        req.p_raddr = head;
      end
      S_LINK_A: begin
        req.n_we    = 1'b1;
        req.n_waddr = ent_q;
        req.n_wdata = head;
        req.p_we    = 1'b1;
        req.p_waddr = ent_q;
        req.p_wdata = tail;
      end
      S_LINK_B: begin
        req.n_we    = 1'b1;
        req.n_waddr = tail_q;
        req.n_wdata = ent_q;
        req.p_we    = 1'b1;
        req.p_waddr = head;
        req.p_wdata = ent_q;
      end
      S_SELF: begin
        req.n_we    = 1'b1;
        req.n_waddr = ent_q;
        req.n_wdata = ent_q;
        req.p_we    = 1'b1;
        req.p_waddr = ent_q;
        req.p_wdata = ent_q;
      end
      S_REMOVE: begin
        if (rsp.n_rdata != ent_q) begin
          req.p_we    = 1'b1;
          req.p_waddr = rsp.n_rdata;
          req.p_wdata = rsp.p_rdata;
          req.n_we    = 1'b1;
          req.n_waddr = rsp.p_rdata;
          req.n_wdata = rsp.n_rdata;
        end
      end
      S_EVICT_A: begin
        if (rsp.p_rdata != head) begin
          req.p_re    = 1'b1;
          req.p_raddr = rsp.p_rdata;
        end
      end
      S_EVICT_B: begin
        req.p_we    = 1'b1;
        req.p_waddr = head;
        req.p_wdata = rsp.p_rdata;
        req.n_we    = 1'b1;
        req.n_waddr = rsp.p_rdata;
        req.n_wdata = head;
      end
      default: begin
      end
    endcase
  end

  // Sequence the command, update head, count and membership, hold the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      limit     <= LIMIT_RESET;
      member    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (eviction_limit_we) begin
        limit <= eviction_limit_wdata;
      end
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            ent_q   <= entry;
            ev_q    <= 1'b0;
            moved_q <= (cmd == CMD_TOUCH) && is_member && !is_head;
            case (cmd)
              CMD_TOUCH: begin
                if (is_member) begin
                  state <= is_head ? S_DONE : S_UNLINK;
                end else if (in_range) begin
                  member[entry[AW-1:0]] <= 1'b1;
                  count <= count + 1'b1;
                  state <= (count == '0) ? S_SELF : S_LINK_A;
                end else begin
                  state <= S_DONE;
                end
              end
              CMD_REMOVE: begin
                if (is_member) begin
                  member[entry[AW-1:0]] <= 1'b0;
                  count <= count - 1'b1;
                  state <= S_REMOVE;
                end else begin
                  state <= S_DONE;
                end
              end
              CMD_MAKE_ROOM: begin
                state <= evict_go ? S_EVICT_A : S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_UNLINK: begin
          nl_q  <= rsp.n_rdata;
          pl_q  <= rsp.p_rdata;
          state <= S_LINK_A;
        end
        S_LINK_A: begin
          tail_q <= tail;
          state  <= S_LINK_B;
        end
        S_LINK_B: begin
          head  <= ent_q;
          state <= S_DONE;
        end
        S_SELF: begin
          head  <= ent_q;
          state <= S_DONE;
        end
        S_REMOVE: begin
          // Advance the head past a removed head unless it was the only entry
          if (rsp.n_rdata != ent_q && head == ent_q) begin
            head <= rsp.n_rdata;
          end
          state <= S_DONE;
        end
        S_EVICT_A: begin
          last_q <= rsp.p_rdata;
          ev_q   <= 1'b1;
          member[rsp.p_rdata[AW-1:0]] <= 1'b0;
          if (rsp.p_rdata == head) begin
            count <= '0;
            state <= S_DONE;
          end else begin
            state <= S_EVICT_B;
          end
        end
        S_EVICT_B: begin
          count <= count - 1'b1;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            evicted_valid <= ev_q;
            evicted_entry <= ev_q ? last_q : '0;
            entry_count   <= count;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/lru_checker.sv
// Port-level checks for the LRU order tracker, bound to the top level.
// Depends on lru_pkg for field widths.

module lru_checker
  import lru_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               evicted_valid,
  input logic [ENTRY_W-1:0] evicted_entry,
  input logic [COUNT_W-1:0] entry_count
);

  logic               out_xfer;
  logic [COUNT_W-1:0] prev_count;

  assign out_xfer = out_valid && !out_stall;

  // Track the count reported by the previous result transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_count <= '0;
    end else if (out_xfer) begin
      prev_count <= entry_count;
    end
  end

  // An accepted command makes the sequencer busy and raises in_stall
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on the cycle after a transaction");

  // An eviction drops the count by exactly one
  a_evict_count: assert property (@(posedge clk) disable iff (rst)
    out_xfer && evicted_valid |-> entry_count == prev_count - 8'd1)
    else $error("eviction did not drop the count by one");

  // Each command changes the count by at most one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    out_xfer |-> ({1'b0, entry_count} <= {1'b0, prev_count} + 9'd1) &&
                 ({1'b0, entry_count} + 9'd1 >= {1'b0, prev_count}))
    else $error("count moved by more than one");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(evicted_valid) &&
                               $stable(evicted_entry) && $stable(entry_count))
    else $error("stalled result changed");

endmodule

bind lru_order_tracker_top lru_checker u_lru_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .evicted_valid (evicted_valid),
  .evicted_entry (evicted_entry),
  .entry_count   (entry_count)
);
